@@ rtl/core/pfr_pkg.sv @@
// ----------------------------------------------------------------------------
// Page frame replacement package
// Shared constants, register indexes and the control/status types that join
// the controller and the datapath.
// ----------------------------------------------------------------------------
package pfr_pkg;

    localparam int FRAMES   = 64;
    localparam int FRAME_W  = $clog2(FRAMES);
    localparam int COUNT_W  = $clog2(FRAMES + 1);
    localparam int PID_W    = 4;
    localparam int PAGE_W   = 16;
    localparam int TIME_W   = 32;
    localparam int RND_W    = 31;
    localparam int POLICY_W = 2;
    localparam int FCOUNT_W = 7;
    localparam int CFG_W    = 7;
    localparam int CFG_IDX_W = 2;

    localparam logic [POLICY_W-1:0]  POL_LRU  = 2'd0;
    localparam logic [POLICY_W-1:0]  POL_FIFO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POLICY      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 2'd1;

    typedef struct packed {
        logic [PID_W-1:0]  owner;
        logic [PAGE_W-1:0] page;
        logic [TIME_W-1:0] load_time;
    } frame_entry_t;

    typedef struct packed {
        logic accept;
        logic scan_cmp;
        logic idx_dec;
        logic take_hit;
        logic take_free;
        logic take_qf;
        logic take_mod;
        logic qi_clr;
        logic qi_inc;
        logic q_rd_next;
        logic q_shift_wr;
        logic q_end_wr;
        logic q_push;
        logic mod_start;
        logic vict_rd;
        logic vict_cap;
        logic load;
        logic result_ld;
    } pfr_cmd_t;

    typedef struct packed {
        logic match;
        logic idx_zero;
        logic free_found;
        logic queued;
        logic lru;
        logic q_empty;
        logic q_match;
        logic q_last;
        logic mod_busy;
    } pfr_sts_t;

endpackage

@@ rtl/core/pfr_mod.sv @@
// ----------------------------------------------------------------------------
// Random word modulo unit
// Restoring remainder, one dividend bit per cycle, for the random victim.
// ----------------------------------------------------------------------------
module pfr_mod (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [pfr_pkg::RND_W-1:0]    dividend,
    input  logic [pfr_pkg::COUNT_W-1:0]  divisor,
    output logic                         busy,
    output logic [pfr_pkg::COUNT_W-1:0]  remainder
);
    import pfr_pkg::*;

    localparam int STEP_W = $clog2(RND_W + 1);

    logic [STEP_W-1:0]  cnt_reg, cnt_next;
    logic [RND_W-1:0]   dvd_reg, dvd_next;
    logic [COUNT_W-1:0] rem_reg, rem_next;
    logic [COUNT_W-1:0] dsr_reg, dsr_next;
    logic [COUNT_W:0]   trial;

    always_comb begin
        cnt_next = cnt_reg;
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        trial    = {rem_reg, dvd_reg[RND_W-1]};
        if (start) begin
            cnt_next = STEP_W'(RND_W);
            dvd_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - 1'b1;
            dvd_next = {dvd_reg[RND_W-2:0], 1'b0};
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = COUNT_W'(trial - {1'b0, dsr_reg});
            end else begin
                rem_next = trial[COUNT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy      = (cnt_reg != '0);
    assign remainder = rem_reg;

endmodule

@@ rtl/core/pfr_datapath.sv @@
// ----------------------------------------------------------------------------
// Page frame replacement datapath
// Frame table, valid bits, order queue, configuration and result registers.
// ----------------------------------------------------------------------------
module pfr_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  pfr_pkg::pfr_cmd_t             cmd,
    output pfr_pkg::pfr_sts_t             sts,
    input  logic                          cfg_wr_en,
    input  logic [pfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pfr_pkg::CFG_W-1:0]     cfg_data,
    input  logic [pfr_pkg::PID_W-1:0]     s_process_id,
    input  logic [pfr_pkg::PAGE_W-1:0]    s_page_number,
    input  logic [pfr_pkg::TIME_W-1:0]    s_ref_time,
    input  logic [pfr_pkg::RND_W-1:0]     s_random_value,
    output logic                          m_fault,
    output logic [5:0]                    m_frame_index,
    output logic                          m_evicted,
    output logic [pfr_pkg::PID_W-1:0]     m_victim_owner,
    output logic [pfr_pkg::PAGE_W-1:0]    m_victim_page,
    output logic [pfr_pkg::TIME_W-1:0]    m_residency
);
    import pfr_pkg::*;

    logic [POLICY_W-1:0] policy_reg;
    logic [FCOUNT_W-1:0] fcount_reg;
    logic [FRAMES-1:0]   valid_reg;
    logic [COUNT_W-1:0]  qlen_reg;
    logic [COUNT_W-1:0]  active_n;

    logic [PID_W-1:0]  pid_reg;
    logic [PAGE_W-1:0] page_reg;
    logic [TIME_W-1:0] time_reg;
    logic [RND_W-1:0]  rnd_reg;

    logic [FRAME_W-1:0] idx_reg, free_reg, f_reg, qi_reg;
    logic               free_found_reg, hit_reg;
    logic               ev_reg;
    logic [PID_W-1:0]   v_owner_reg;
    logic [PAGE_W-1:0]  v_page_reg;
    logic [TIME_W-1:0]  v_res_reg;

    frame_entry_t       frame_mem [FRAMES];
    frame_entry_t       frd_reg;
    logic [FRAME_W-1:0] frd_addr;

    logic [FRAME_W-1:0] queue_mem [FRAMES];
    logic [FRAME_W-1:0] qrd_reg;
    logic [FRAME_W-1:0] qrd_addr, qwr_addr, qwr_data;
    logic               qwr_en;

    logic               mod_busy;
    logic [COUNT_W-1:0] mod_rem;
    logic [COUNT_W-1:0] last_pos;

    always_comb begin
        if (fcount_reg == '0) begin
            active_n = COUNT_W'(1);
        end else if (fcount_reg > FCOUNT_W'(FRAMES)) begin
            active_n = COUNT_W'(FRAMES);
        end else begin
            active_n = COUNT_W'(fcount_reg);
        end
    end

    pfr_mod u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.mod_start),
        .dividend  (rnd_reg),
        .divisor   (active_n),
        .busy      (mod_busy),
        .remainder (mod_rem)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg <= POL_LRU;
            fcount_reg <= FCOUNT_W'(64);
            valid_reg  <= '0;
            qlen_reg   <= '0;
        end else if (cfg_wr_en && (cfg_index == REG_POLICY ||
                                   cfg_index == REG_FRAME_COUNT)) begin
            if (cfg_index == REG_POLICY) begin
                policy_reg <= cfg_data[POLICY_W-1:0];
            end else begin
                fcount_reg <= cfg_data[FCOUNT_W-1:0];
            end
            valid_reg <= '0;
            qlen_reg  <= '0;
        end else begin
            if (cmd.load) begin
                valid_reg[f_reg] <= 1'b1;
            end
            if (cmd.q_push && qlen_reg < COUNT_W'(FRAMES)) begin
                qlen_reg <= qlen_reg + 1'b1;
            end
        end
    end

    assign frd_addr = cmd.vict_rd ? f_reg : idx_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            frame_mem[f_reg] <= '{owner: pid_reg, page: page_reg, load_time: time_reg};
        end
        frd_reg <= frame_mem[frd_addr];
    end

    assign last_pos = qlen_reg - 1'b1;
    assign qrd_addr = cmd.q_rd_next ? qi_reg + 1'b1 : qi_reg;
    assign qwr_en   = cmd.q_shift_wr || cmd.q_end_wr ||
                      (cmd.q_push && qlen_reg < COUNT_W'(FRAMES));
    assign qwr_data = cmd.q_shift_wr ? qrd_reg : f_reg;

    always_comb begin
        if (cmd.q_shift_wr) begin
            qwr_addr = qi_reg;
        end else if (cmd.q_end_wr) begin
            qwr_addr = last_pos[FRAME_W-1:0];
        end else begin
            qwr_addr = qlen_reg[FRAME_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (qwr_en) begin
            queue_mem[qwr_addr] <= qwr_data;
        end
        qrd_reg <= queue_mem[qrd_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            pid_reg        <= s_process_id;
            page_reg       <= s_page_number;
            time_reg       <= s_ref_time;
            rnd_reg        <= s_random_value;
            idx_reg        <= FRAME_W'(active_n - 1'b1);
            free_found_reg <= 1'b0;
            hit_reg        <= 1'b0;
            ev_reg         <= 1'b0;
            v_owner_reg    <= '0;
            v_page_reg     <= '0;
            v_res_reg      <= '0;
        end
        if (cmd.scan_cmp && !valid_reg[idx_reg] && !free_found_reg) begin
            free_reg       <= idx_reg;
            free_found_reg <= 1'b1;
        end
        if (cmd.idx_dec) begin
            idx_reg <= idx_reg - 1'b1;
        end
        if (cmd.take_hit) begin
            f_reg   <= idx_reg;
            hit_reg <= 1'b1;
        end else if (cmd.take_free) begin
            f_reg <= free_reg;
        end else if (cmd.take_qf) begin
            f_reg <= qrd_reg;
        end else if (cmd.take_mod) begin
            f_reg <= mod_rem[FRAME_W-1:0];
        end
        if (cmd.qi_clr) begin
            qi_reg <= '0;
        end else if (cmd.qi_inc) begin
            qi_reg <= qi_reg + 1'b1;
        end
        if (cmd.vict_cap) begin
            ev_reg      <= 1'b1;
            v_owner_reg <= frd_reg.owner;
            v_page_reg  <= frd_reg.page;
            v_res_reg   <= time_reg - frd_reg.load_time;
        end
        if (cmd.result_ld) begin
            m_fault        <= !hit_reg;
            m_frame_index  <= f_reg[5:0];
            m_evicted      <= ev_reg;
            m_victim_owner <= v_owner_reg;
            m_victim_page  <= v_page_reg;
            m_residency    <= v_res_reg;
        end
    end

    assign sts.match      = valid_reg[idx_reg] && frd_reg.owner == pid_reg &&
                            frd_reg.page == page_reg;
    assign sts.idx_zero   = (idx_reg == '0);
    assign sts.free_found = free_found_reg;
    assign sts.queued     = (policy_reg == POL_LRU || policy_reg == POL_FIFO);
    assign sts.lru        = (policy_reg == POL_LRU);
    assign sts.q_empty    = (qlen_reg == '0);
    assign sts.q_match    = (qrd_reg == f_reg);
    assign sts.q_last     = ({1'b0, qi_reg} + 1'b1 >= qlen_reg);
    assign sts.mod_busy   = mod_busy;

endmodule

@@ rtl/core/pfr_ctrl.sv @@
// ----------------------------------------------------------------------------
// Page frame replacement controller
// Sequences the table scan, queue update, victim choice and result hand-off.
// ----------------------------------------------------------------------------
module pfr_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  pfr_pkg::pfr_sts_t sts,
    output pfr_pkg::pfr_cmd_t cmd
);
    import pfr_pkg::*;

    localparam logic [4:0] ST_IDLE     = 5'd0;
    localparam logic [4:0] ST_SCAN_RD  = 5'd1;
    localparam logic [4:0] ST_SCAN_CMP = 5'd2;
    localparam logic [4:0] ST_QS_RD    = 5'd3;
    localparam logic [4:0] ST_QS_CMP   = 5'd4;
    localparam logic [4:0] ST_SH_CHK   = 5'd5;
    localparam logic [4:0] ST_SH_RD    = 5'd6;
    localparam logic [4:0] ST_SH_WR    = 5'd7;
    localparam logic [4:0] ST_QEND     = 5'd8;
    localparam logic [4:0] ST_MISS     = 5'd9;
    localparam logic [4:0] ST_EVQ_RD   = 5'd10;
    localparam logic [4:0] ST_EVQ      = 5'd11;
    localparam logic [4:0] ST_MOD      = 5'd12;
    localparam logic [4:0] ST_VICT_RD  = 5'd13;
    localparam logic [4:0] ST_VICT     = 5'd14;
    localparam logic [4:0] ST_LOAD     = 5'd15;
    localparam logic [4:0] ST_QPUSH    = 5'd16;
    localparam logic [4:0] ST_DONE     = 5'd17;

    logic [4:0] state_reg, state_next;
    logic       evq_reg, evq_next;
    logic       out_valid_reg, out_valid_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;

    always_comb begin
        state_next     = state_reg;
        evq_next       = evq_reg;
        out_valid_next = out_valid_reg && !m_ready;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD: begin
                state_next = ST_SCAN_CMP;
            end
            ST_SCAN_CMP: begin
                cmd.scan_cmp = 1'b1;
                if (sts.match) begin
                    cmd.take_hit = 1'b1;
                    if (sts.lru && !sts.q_empty) begin
                        cmd.qi_clr = 1'b1;
                        state_next = ST_QS_RD;
                    end else begin
                        state_next = ST_DONE;
                    end
                end else if (sts.idx_zero) begin
                    state_next = ST_MISS;
                end else begin
                    cmd.idx_dec = 1'b1;
                    state_next  = ST_SCAN_RD;
                end
            end
            ST_QS_RD: begin
                state_next = ST_QS_CMP;
            end
            ST_QS_CMP: begin
                if (sts.q_match) begin
                    state_next = ST_SH_CHK;
                end else if (sts.q_last) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.qi_inc = 1'b1;
                    state_next = ST_QS_RD;
                end
            end
            ST_SH_CHK: begin
                state_next = sts.q_last ? ST_QEND : ST_SH_RD;
            end
            ST_SH_RD: begin
                cmd.q_rd_next = 1'b1;
                state_next    = ST_SH_WR;
            end
            ST_SH_WR: begin
                cmd.q_shift_wr = 1'b1;
                cmd.qi_inc     = 1'b1;
                state_next     = ST_SH_CHK;
            end
            ST_QEND: begin
                cmd.q_end_wr = 1'b1;
                state_next   = ST_DONE;
            end
            ST_MISS: begin
                if (sts.free_found) begin
                    cmd.take_free = 1'b1;
                    evq_next      = 1'b0;
                    state_next    = ST_LOAD;
                end else if (sts.queued && !sts.q_empty) begin
                    cmd.qi_clr = 1'b1;
                    state_next = ST_EVQ_RD;
                end else begin
                    cmd.mod_start = 1'b1;
                    evq_next      = 1'b0;
                    state_next    = ST_MOD;
                end
            end
            ST_EVQ_RD: begin
                state_next = ST_EVQ;
            end
            ST_EVQ: begin
                cmd.take_qf = 1'b1;
                evq_next    = 1'b1;
                state_next  = ST_VICT_RD;
            end
            ST_MOD: begin
                if (!sts.mod_busy) begin
                    cmd.take_mod = 1'b1;
                    state_next   = ST_VICT_RD;
                end
            end
            ST_VICT_RD: begin
                cmd.vict_rd = 1'b1;
                state_next  = ST_VICT;
            end
            ST_VICT: begin
                cmd.vict_rd  = 1'b1;
                cmd.vict_cap = 1'b1;
                state_next   = ST_LOAD;
            end
            ST_LOAD: begin
                cmd.load = 1'b1;
                if (evq_reg) begin
                    state_next = ST_SH_CHK;
                end else if (sts.queued) begin
                    state_next = ST_QPUSH;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_QPUSH: begin
                cmd.q_push = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    cmd.result_ld  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            evq_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            evq_reg       <= evq_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("Result raised outside the completion state.");

    a_idle_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && !s_valid) |=> state_reg == ST_IDLE)
        else $error("Controller left idle without a request.");

    a_done_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && out_valid_reg && !m_ready) |=> state_reg == ST_DONE)
        else $error("Result overwritten before it was taken.");

endmodule

@@ rtl/core/page_frame_replacement.sv @@
// ----------------------------------------------------------------------------
// Page frame replacement unit
// A request scans the frame table from the highest active frame down to the first match.
// A hit ends the scan; a least-recently-used hit also moves its frame to the queue end.
// A miss scans all active frames, then loads a free frame (with a queue push in the queued
// policies), a random victim, or the head of the queue as victim.
// One request at a time: the next is accepted the cycle after the result is registered.
// Reset is synchronous and empties the frame table.
// ----------------------------------------------------------------------------
module page_frame_replacement (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [pfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pfr_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [pfr_pkg::PID_W-1:0]     s_process_id,
    input  logic [pfr_pkg::PAGE_W-1:0]    s_page_number,
    input  logic [pfr_pkg::TIME_W-1:0]    s_ref_time,
    input  logic [pfr_pkg::RND_W-1:0]     s_random_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_fault,
    output logic [5:0]                    m_frame_index,
    output logic                          m_evicted,
    output logic [pfr_pkg::PID_W-1:0]     m_victim_owner,
    output logic [pfr_pkg::PAGE_W-1:0]    m_victim_page,
    output logic [pfr_pkg::TIME_W-1:0]    m_residency
);
    import pfr_pkg::*;

    pfr_cmd_t cmd;
    pfr_sts_t sts;

    pfr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    pfr_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_process_id   (s_process_id),
        .s_page_number  (s_page_number),
        .s_ref_time     (s_ref_time),
        .s_random_value (s_random_value),
        .m_fault        (m_fault),
        .m_frame_index  (m_frame_index),
        .m_evicted      (m_evicted),
        .m_victim_owner (m_victim_owner),
        .m_victim_page  (m_victim_page),
        .m_residency    (m_residency)
    );

endmodule
